// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/fyse_pkg.sv =====
// ----------------------------------------------------------------------------
// fyse_pkg
// Shared types and codes of the shuffle engine.
// ----------------------------------------------------------------------------
package fyse_pkg;

	// Operation codes of an item
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_STEP    = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;
	localparam logic [1:0] FUNC_RESTART = 2'd3;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_ELEMENT_COUNT = 2'd0;
	localparam logic [1:0] REG_PARTIAL_COUNT = 2'd1;
	localparam logic [1:0] REG_SHUFFLE_MODE  = 2'd2;

	// Width of an internal element position
	localparam int POS_W = 8;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] slot;
		logic [7:0] load_value;
		logic [7:0] random_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic [5:0] partner_slot;
		logic       run_finished;
		logic       step_ignored;
	} out_item_t;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [6:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic       done;
		logic [6:0] remainder;
	} mod_resp_t;

endpackage

// ===== hw/rtl/fyse_mod_unit.sv =====
// ----------------------------------------------------------------------------
// fyse_mod_unit
// Restoring remainder unit: 8-bit dividend by 7-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module fyse_mod_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fyse_pkg::mod_req_t   req,
	output fyse_pkg::mod_resp_t  resp
);
	import fyse_pkg::*;

	localparam logic [3:0] MOD_STEPS = 4'd8;

	logic [7:0] x_q;
	logic [6:0] d_q;
	logic [7:0] r_q;
	logic [3:0] cnt_q;
	logic       done_q;

	logic [7:0] r_shift;
	logic [7:0] r_next;

	// Shift in the next dividend bit, subtract when it fits
	always_comb begin
		r_shift = {r_q[6:0], x_q[7]};
		if (r_shift >= {1'b0, d_q}) begin
			r_next = r_shift - {1'b0, d_q};
		end else begin
			r_next = r_shift;
		end
	end

	// Iterate over the dividend bits, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			d_q    <= '0;
			r_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == 4'd1);
			if (req.start) begin
				x_q   <= req.dividend;
				d_q   <= req.divisor;
				r_q   <= '0;
				cnt_q <= MOD_STEPS;
			end else if (cnt_q != 4'd0) begin
				x_q   <= {x_q[6:0], 1'b0};
				r_q   <= r_next;
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	assign resp.done      = done_q;
	assign resp.remainder = r_q[6:0];

endmodule

// ===== hw/rtl/fyse_elem_ram.sv =====
// ----------------------------------------------------------------------------
// fyse_elem_ram
// Element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fyse_elem_ram #(
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fisher_yates_shuffle_engine.sv =====
// ----------------------------------------------------------------------------
// fisher_yates_shuffle_engine
// In-place byte array shuffle driven by supplied random bytes.
// ----------------------------------------------------------------------------
// A load, restart or ignored step is resolved in dispatch; a read also waits for the
// registered read data; a swapping step waits on the remainder unit, then does the
// read-read-write-write swap. One item in flight: the next is taken the cycle after
// the result enters the output register. Reset clears the cursor, marks the run
// finished and loads the registers with 64, 0, 0; element contents are undefined
// until loaded.
module fisher_yates_shuffle_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  fyse_pkg::in_item_t   cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output fyse_pkg::out_item_t  rsp
);
	import fyse_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_ELEMENTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ_WAIT,
		S_MOD,
		S_RD_CUR,
		S_RD_PART,
		S_WR_CUR,
		S_WR_PART,
		S_DONE
	} state_t;

	state_t     state_q;
	in_item_t   item_q;
	out_item_t  res_q;
	out_item_t  rsp_q;
	logic       rsp_valid_q;
	logic [6:0] cursor_q;
	logic       run_done_q;
	logic [6:0] partner_q;
	logic [7:0] swap_tmp_q;
	logic [6:0] elem_count_q;
	logic [6:0] part_count_q;
	logic       mode_q;

	logic [POS_W-1:0] n_wide;
	logic [6:0]       n_eff;
	logic [6:0]       k_eff;
	logic [POS_W-1:0] slot_pos;
	logic [POS_W-1:0] cur_pos;
	logic [POS_W-1:0] part_pos;
	logic             slot_ok;
	logic             step_end;
	logic             cfg_wr;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	mod_req_t  mod_req;
	mod_resp_t mod_resp;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_count_q <= 7'd64;
			part_count_q <= 7'd0;
			mode_q       <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ELEMENT_COUNT: elem_count_q <= pwdata[6:0];
				REG_PARTIAL_COUNT: part_count_q <= pwdata[6:0];
				REG_SHUFFLE_MODE:  mode_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ELEMENT_COUNT: prdata = {25'd0, elem_count_q};
			REG_PARTIAL_COUNT: prdata = {25'd0, part_count_q};
			REG_SHUFFLE_MODE:  prdata = {31'd0, mode_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Effective counts and positions
	always_comb begin
		n_wide = {1'b0, elem_count_q};
		if (n_wide > MAX_POS) begin
			n_wide = MAX_POS;
		end
		n_eff = n_wide[6:0];
		k_eff = (part_count_q > n_eff) ? n_eff : part_count_q;
	end

	assign slot_pos = {2'b00, item_q.slot};
	assign cur_pos  = {1'b0, cursor_q};
	assign part_pos = {1'b0, partner_q};
	assign slot_ok  = slot_pos < MAX_POS;

	// A step that finds its cursor out of range ends the run
	always_comb begin
		if (!mode_q) begin
			step_end = (cursor_q == 7'd0) || (cursor_q >= n_eff);
		end else begin
			step_end = (cursor_q >= k_eff) || (cursor_q >= n_eff);
		end
	end

	// Start the remainder unit for a step that swaps
	always_comb begin
		mod_req.start    = (state_q == S_DISPATCH) && (item_q.func == FUNC_STEP) &&
		                   !run_done_q && !step_end;
		mod_req.dividend = item_q.random_byte;
		mod_req.divisor  = mode_q ? (n_eff - cursor_q) : (cursor_q + 7'd1);
	end

	fyse_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.resp   (mod_resp)
	);

	// Element store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_DISPATCH: begin
				if (item_q.func == FUNC_LOAD && slot_ok) begin
					mem_we    = 1'b1;
					mem_waddr = slot_pos[AW-1:0];
					mem_wdata = item_q.load_value;
				end
				if (item_q.func == FUNC_READ && slot_ok) begin
					mem_re    = 1'b1;
					mem_raddr = slot_pos[AW-1:0];
				end
			end
			S_RD_CUR: begin
				mem_re    = 1'b1;
				mem_raddr = cur_pos[AW-1:0];
			end
			S_RD_PART: begin
				mem_re    = 1'b1;
				mem_raddr = part_pos[AW-1:0];
			end
			S_WR_CUR: begin
				mem_we    = 1'b1;
				mem_waddr = cur_pos[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_WR_PART: begin
				mem_we    = 1'b1;
				mem_waddr = part_pos[AW-1:0];
				mem_wdata = swap_tmp_q;
			end
			default: ;
		endcase
	end

	fyse_elem_ram #(
		.DEPTH (MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer: decode the item, run the step, hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			cursor_q    <= '0;
			run_done_q  <= 1'b1;
			partner_q   <= '0;
			swap_tmp_q  <= '0;
		end else begin
			// Drop the output item once taken, unless a new one replaces it
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						item_q  <= cmd;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					res_q.read_value   <= '0;
					res_q.partner_slot <= '0;
					unique case (item_q.func)
						FUNC_LOAD: begin
							res_q.run_finished <= run_done_q;
							res_q.step_ignored <= 1'b0;
							state_q            <= S_DONE;
						end
						FUNC_READ: begin
							res_q.run_finished <= run_done_q;
							res_q.step_ignored <= 1'b0;
							state_q            <= S_READ_WAIT;
						end
						FUNC_RESTART: begin
							res_q.step_ignored <= 1'b0;
							state_q            <= S_DONE;
							if (!mode_q) begin
								if (n_eff >= 7'd2) begin
									cursor_q           <= n_eff - 7'd1;
									run_done_q         <= 1'b0;
									res_q.run_finished <= 1'b0;
								end else begin
									cursor_q           <= '0;
									run_done_q         <= 1'b1;
									res_q.run_finished <= 1'b1;
								end
							end else begin
								cursor_q           <= '0;
								run_done_q         <= (k_eff == 7'd0);
								res_q.run_finished <= (k_eff == 7'd0);
							end
						end
						FUNC_STEP: begin
							if (run_done_q) begin
								res_q.run_finished <= 1'b1;
								res_q.step_ignored <= 1'b1;
								state_q            <= S_DONE;
							end else if (step_end) begin
								run_done_q         <= 1'b1;
								res_q.run_finished <= 1'b1;
								res_q.step_ignored <= 1'b1;
								state_q            <= S_DONE;
							end else begin
								res_q.step_ignored <= 1'b0;
								state_q            <= S_MOD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_READ_WAIT: begin
					res_q.read_value <= slot_ok ? mem_rdata : 8'd0;
					state_q          <= S_DONE;
				end
				S_MOD: begin
					if (mod_resp.done) begin
						partner_q <= mode_q ? (cursor_q + mod_resp.remainder)
						                    : mod_resp.remainder;
						state_q   <= S_RD_CUR;
					end
				end
				S_RD_CUR: state_q <= S_RD_PART;
				S_RD_PART: begin
					// Hold the cursor element while the partner is read
					swap_tmp_q <= mem_rdata;
					state_q    <= S_WR_CUR;
				end
				S_WR_CUR: state_q <= S_WR_PART;
				S_WR_PART: begin
					res_q.partner_slot <= partner_q[5:0];
					if (!mode_q) begin
						cursor_q           <= cursor_q - 7'd1;
						run_done_q         <= (cursor_q == 7'd1);
						res_q.run_finished <= (cursor_q == 7'd1);
					end else begin
						cursor_q           <= cursor_q + 7'd1;
						run_done_q         <= ((cursor_q + 7'd1) >= k_eff);
						res_q.run_finished <= ((cursor_q + 7'd1) >= k_eff);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An active run keeps its cursor inside the element store
	`ASSERT_IMPLY(a_cursor_in_store, clk, arst_n, !run_done_q, ({1'b0, cursor_q} < MAX_POS), "cursor beyond element store during a run")

	// The remainder unit only finishes while the sequencer waits for it
	`ASSERT_IMPLY(a_mod_done_in_wait, clk, arst_n, mod_resp.done, (state_q == S_MOD), "remainder result outside the wait state")

	// A swap partner always lies inside the element store
	`ASSERT_IMPLY(a_partner_in_store, clk, arst_n, (state_q == S_RD_PART), (part_pos < MAX_POS), "swap partner beyond element store")

endmodule
